FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL.
// With SYNTH defined, every macro expands to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// A condition that must hold in the cycle after the trigger.
`define ASSERT_NEXT(lbl, clk, rst, trig, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (expr)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_NEXT(lbl, clk, rst, trig, expr)

`endif

`endif

FILE: hdl/stm_pkg.sv
package stm_pkg;

   // Default table sizes.
   localparam int MAX_TASKS_DEF      = 16;
   localparam int MAX_LIST_ITEMS_DEF = 8;

   // Fixed field widths.
   localparam int NUM_FIELDS = 5;
   localparam int COND_W     = 15;
   localparam int ITEM_W     = 6;
   localparam int TIME_W     = 6;
   localparam int MASK_W     = 16;
   localparam int COUNT_W    = 5;

   // Request actions.
   localparam logic [1:0] ACT_WR_COND = 2'd0;
   localparam logic [1:0] ACT_WR_ITEM = 2'd1;
   localparam logic [1:0] ACT_TICK    = 2'd2;

   // Condition kinds.
   localparam logic [1:0] KIND_SINGLE = 2'd0;
   localparam logic [1:0] KIND_LIST   = 2'd1;
   localparam logic [1:0] KIND_RANGE  = 2'd2;

   // A single value of minus one matches any time value.
   localparam logic signed [6:0] WILDCARD = -7'sd1;

   // Tick time, one zero-extended value per field.
   typedef logic [NUM_FIELDS-1:0][TIME_W-1:0] stm_time_type;

   // Table write request handed to both memories.
   typedef struct packed {
      logic              cond_we;
      logic              list_we;
      logic [3:0]        task_idx;
      logic [2:0]        field_sel;
      logic [2:0]        list_slot;
      logic [COND_W-1:0] cond_word;
      logic [ITEM_W-1:0] item;
   } stm_wr_type;

endpackage

FILE: hdl/stm_cond_mem.sv
module stm_cond_mem
   import stm_pkg::*;
#(
   parameter int MAX_TASKS = MAX_TASKS_DEF,
   parameter int TASK_AW   = 4
) (
   input  logic                           clock,
   input  stm_wr_type                     wr,
   input  logic                           rd_en,
   input  logic [TASK_AW-1:0]             rd_addr,
   output logic [NUM_FIELDS*COND_W-1:0]   rd_data
);

   // One row per task, one lane per time field.
   logic [NUM_FIELDS*COND_W-1:0] mem [MAX_TASKS];
   logic [NUM_FIELDS*COND_W-1:0] rd_data_ff;
   logic                         wr_ok;

   assign wr_ok = wr.cond_we && (32'(wr.task_idx) < MAX_TASKS);

   // Lane write: only the addressed field of the row changes.
   always_ff @(posedge clock) begin
      for (int f = 0; f < NUM_FIELDS; f++) begin
         if (wr_ok && wr.field_sel == 3'(f)) begin
            mem[TASK_AW'(wr.task_idx)][f*COND_W +: COND_W] <= wr.cond_word;
         end
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/stm_list_mem.sv
module stm_list_mem
   import stm_pkg::*;
#(
   parameter int MAX_TASKS      = MAX_TASKS_DEF,
   parameter int MAX_LIST_ITEMS = MAX_LIST_ITEMS_DEF,
   parameter int TASK_AW        = 4
) (
   input  logic                                          clock,
   input  stm_wr_type                                    wr,
   input  logic                                          rd_en,
   input  logic [TASK_AW-1:0]                            rd_addr,
   output logic [NUM_FIELDS*MAX_LIST_ITEMS*ITEM_W-1:0]   rd_data
);

   localparam int ROW_W = NUM_FIELDS * MAX_LIST_ITEMS * ITEM_W;

   // One row per task holding every list item of all five fields.
   logic [ROW_W-1:0] mem [MAX_TASKS];
   logic [ROW_W-1:0] rd_data_ff;
   logic             wr_ok;

   assign wr_ok = wr.list_we && (32'(wr.task_idx) < MAX_TASKS);

   // Item write: only the addressed item lane of the row changes.
   always_ff @(posedge clock) begin
      for (int f = 0; f < NUM_FIELDS; f++) begin
         for (int s = 0; s < MAX_LIST_ITEMS; s++) begin
            if (wr_ok && wr.field_sel == 3'(f) && 32'(wr.list_slot) == s) begin
               mem[TASK_AW'(wr.task_idx)][(f*MAX_LIST_ITEMS + s)*ITEM_W +: ITEM_W]
                  <= wr.item;
            end
         end
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/stm_match_eval.sv
module stm_match_eval
   import stm_pkg::*;
#(
   parameter int MAX_LIST_ITEMS = MAX_LIST_ITEMS_DEF
) (
   input  logic [NUM_FIELDS*COND_W-1:0]                  cond_row,
   input  logic [NUM_FIELDS*MAX_LIST_ITEMS*ITEM_W-1:0]   list_row,
   input  stm_time_type                                  now,
   output logic                                          hit
);

   logic [NUM_FIELDS-1:0] field_ok;

   // Evaluate the five field conditions of one task side by side.
   always_comb begin
      logic [COND_W-1:0]   cond;
      logic [1:0]          kind;
      logic signed [6:0]   val_a;
      logic [5:0]          val_b;
      logic [TIME_W-1:0]   t;
      logic signed [6:0]   t_s;
      logic                list_hit;
      logic [ITEM_W-1:0]   item;

      for (int f = 0; f < NUM_FIELDS; f++) begin
         cond  = cond_row[f*COND_W +: COND_W];
         kind  = cond[1:0];
         val_a = $signed(cond[8:2]);
         val_b = cond[14:9];
         t     = now[f];
         t_s   = $signed({1'b0, t});

         // A list matches when any of its first val_b items equals the time.
         list_hit = 1'b0;
         for (int i = 0; i < MAX_LIST_ITEMS; i++) begin
            item = list_row[(f*MAX_LIST_ITEMS + i)*ITEM_W +: ITEM_W];
            if (6'(i) < val_b && item == t) begin
               list_hit = 1'b1;
            end
         end

         case (kind)
            KIND_SINGLE: field_ok[f] = (val_a == WILDCARD) || (val_a == t_s);
            KIND_LIST:   field_ok[f] = list_hit;
            KIND_RANGE:  field_ok[f] = (t_s >= val_a) && (t <= val_b);
            default:     field_ok[f] = 1'b0;
         endcase
      end
   end

   assign hit = &field_ok;

endmodule

FILE: hdl/schedule_time_matcher.sv
// Schedule time matcher: a table of tasks, each with five time-field
// conditions, and a tick request that returns the mask of matching tasks.
//
// Request channel: a request is taken at a rising edge with start high and
// busy low. Writes of a field condition or of a list item update the table
// at that edge and are acknowledged in the next cycle with is_tick low and a
// zero mask; busy stays low, so writes can follow in every cycle.
// A tick with a nonzero task_count raises busy and walks the tasks below
// task_count, capped at the smaller of table size and mask width, one row
// a cycle through both memories. With task_count zero the tick is answered
// in the next cycle and busy stays low. busy falls with the response, so
// the next request can be taken at the edge that ends the response cycle.
// Response channel: rsp_valid marks each response for exactly one cycle and
// the receiver has no way to hold it off.
// Configuration: csr_wr_data is loaded into task_count on csr_wr_en, which
// the user must raise only while the block is idle; the block does not enforce it.
// Reset clears task_count and the control state. Table contents are
// undefined until the host writes them.
`include "assert_macros.svh"

module schedule_time_matcher
   import stm_pkg::*;
#(
   parameter int MAX_TASKS      = MAX_TASKS_DEF,
   parameter int MAX_LIST_ITEMS = MAX_LIST_ITEMS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_action,
   input  logic [3:0]          req_task_index,
   input  logic [2:0]          req_field_select,
   input  logic [1:0]          req_kind,
   input  logic signed [6:0]   req_value_a,
   input  logic [5:0]          req_value_b,
   input  logic [2:0]          req_list_slot,
   input  logic [5:0]          req_minute,
   input  logic [4:0]          req_hour,
   input  logic [4:0]          req_day_of_month,
   input  logic [3:0]          req_month_number,
   input  logic [2:0]          req_weekday,
   output logic                rsp_valid,
   output logic [MASK_W-1:0]   rsp_match_mask,
   output logic                rsp_is_tick,
   input  logic                csr_wr_en,
   input  logic [COUNT_W-1:0]  csr_wr_data
);

   localparam int TASK_AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam logic [COUNT_W-1:0] TASK_CAP =
      COUNT_W'((MAX_TASKS < MASK_W) ? MAX_TASKS : MASK_W);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_LAST = 3'b100
   } stm_state_type;

   stm_state_type        state_ff, state_in;
   logic [COUNT_W-1:0]   task_count_ff;
   logic [COUNT_W-1:0]   n_ff, n_in;
   logic [3:0]           cnt_ff, cnt_in;
   logic [3:0]           rd_idx_ff, rd_idx_in;
   logic                 rd_valid_ff, rd_valid_in;
   logic [MASK_W-1:0]    mask_ff, mask_in;
   stm_time_type         now_ff, now_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_is_tick_ff, rsp_is_tick_in;
   logic [MASK_W-1:0]    rsp_mask_ff, rsp_mask_in;

   logic                 accept;
   logic [COUNT_W-1:0]   n_cap;
   logic                 rd_en;
   logic [TASK_AW-1:0]   rd_addr;
   stm_wr_type           wr;
   logic                 hit;
   logic [MASK_W-1:0]    mask_acc;
   logic [NUM_FIELDS*COND_W-1:0]                 cond_row;
   logic [NUM_FIELDS*MAX_LIST_ITEMS*ITEM_W-1:0]  list_row;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);
   assign n_cap  = (task_count_ff > TASK_CAP) ? TASK_CAP : task_count_ff;

   // Table write request; the memories take it at the accepting edge.
   always_comb begin
      wr.cond_we   = accept && (req_action == ACT_WR_COND);
      wr.list_we   = accept && (req_action == ACT_WR_ITEM);
      wr.task_idx  = req_task_index;
      wr.field_sel = req_field_select;
      wr.list_slot = req_list_slot;
      wr.cond_word = {req_value_b, req_value_a, req_kind};
      wr.item      = req_value_a[5:0];
   end

   stm_cond_mem #(
      .MAX_TASKS (MAX_TASKS),
      .TASK_AW   (TASK_AW)
   ) u_cond_mem (
      .clock   (clock),
      .wr      (wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (cond_row)
   );

   stm_list_mem #(
      .MAX_TASKS      (MAX_TASKS),
      .MAX_LIST_ITEMS (MAX_LIST_ITEMS),
      .TASK_AW        (TASK_AW)
   ) u_list_mem (
      .clock   (clock),
      .wr      (wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (list_row)
   );

   stm_match_eval #(
      .MAX_LIST_ITEMS (MAX_LIST_ITEMS)
   ) u_match_eval (
      .cond_row (cond_row),
      .list_row (list_row),
      .now      (now_ff),
      .hit      (hit)
   );

   assign rd_addr  = TASK_AW'(cnt_ff);
   assign mask_acc = rd_valid_ff ? (mask_ff | (MASK_W'(hit) << rd_idx_ff)) : mask_ff;

   // Sequencer: takes requests when idle; during a tick walk one row is read per
   // cycle and the match of the row read before is folded into the mask.
   always_comb begin
      state_in       = state_ff;
      n_in           = n_ff;
      cnt_in         = cnt_ff;
      rd_idx_in      = rd_idx_ff;
      rd_valid_in    = 1'b0;
      mask_in        = mask_ff;
      now_in         = now_ff;
      rsp_valid_in   = 1'b0;
      rsp_is_tick_in = 1'b0;
      rsp_mask_in    = rsp_mask_ff;
      rd_en          = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_action == ACT_TICK) begin
                  now_in  = {TIME_W'(req_weekday), TIME_W'(req_month_number),
                             TIME_W'(req_day_of_month), TIME_W'(req_hour),
                             req_minute};
                  cnt_in  = '0;
                  mask_in = '0;
                  n_in    = n_cap;
                  if (n_cap == '0) begin
                     rsp_valid_in   = 1'b1;
                     rsp_is_tick_in = 1'b1;
                     rsp_mask_in    = '0;
                  end else begin
                     state_in = ST_READ;
                  end
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_mask_in  = '0;
               end
            end
         end
         ST_READ: begin
            rd_en       = 1'b1;
            rd_valid_in = 1'b1;
            rd_idx_in   = cnt_ff;
            mask_in     = mask_acc;
            cnt_in      = cnt_ff + 4'd1;
            if (COUNT_W'(cnt_ff) + COUNT_W'(1) == n_ff) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            rsp_valid_in   = 1'b1;
            rsp_is_tick_in = 1'b1;
            rsp_mask_in    = mask_acc;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rd_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         rsp_is_tick_ff <= 1'b0;
         task_count_ff  <= '0;
      end else begin
         state_ff       <= state_in;
         rd_valid_ff    <= rd_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         rsp_is_tick_ff <= rsp_is_tick_in;
         if (csr_wr_en) begin
            task_count_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      cnt_ff      <= cnt_in;
      rd_idx_ff   <= rd_idx_in;
      mask_ff     <= mask_in;
      now_ff      <= now_in;
      rsp_mask_ff <= rsp_mask_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_is_tick    = rsp_is_tick_ff;
   assign rsp_match_mask = rsp_mask_ff;

   // Checks on the sequencer and the response path.
   `ASSERT_NEXT(a_write_ack, clock, reset, accept && req_action != ACT_TICK,
                rsp_valid && !rsp_is_tick)
   `ASSERT_NEXT(a_tick_busy, clock, reset, accept && req_action == ACT_TICK && n_cap != '0,
                busy && !rsp_valid)
   `ASSERT_ALWAYS(a_ack_zero, clock, reset, !(rsp_valid && !rsp_is_tick) || rsp_match_mask == '0)
   `ASSERT_ALWAYS(a_rd_in_walk, clock, reset, !rd_valid_ff || state_ff == ST_READ || state_ff == ST_LAST)

endmodule

FILE: tb/tb_schedule_time_matcher.sv
`timescale 1ns / 1ps

module tb_schedule_time_matcher;
   import stm_pkg::*;

   // Codes that the package leaves unnamed.
   localparam logic [1:0] ACT_NONE   = 2'd3;
   localparam logic [1:0] KIND_NEVER = 2'd3;
   localparam int FLD_MINUTE  = 0;
   localparam int FLD_HOUR    = 1;
   localparam int FLD_DAY     = 2;
   localparam int FLD_MONTH   = 3;
   localparam int FLD_WEEKDAY = 4;

   localparam int NUM_SLOTS    = MAX_TASKS_DEF * NUM_FIELDS;
   localparam int STALL_LIMIT  = 500;
   localparam int DRAIN_CYCLES = 20;
   localparam int PHASES       = 10;
   localparam int PHASE_ITEMS  = 100;

   typedef struct {
      logic [1:0]        action;
      logic [3:0]        task_index;
      logic [2:0]        field_select;
      logic [1:0]        kind;
      logic signed [6:0] value_a;
      logic [5:0]        value_b;
      logic [2:0]        list_slot;
      logic [5:0]        minute;
      logic [4:0]        hour;
      logic [4:0]        day_of_month;
      logic [3:0]        month_number;
      logic [2:0]        weekday;
   } sched_req_type;

   typedef struct {
      logic [MASK_W-1:0] match_mask;
      logic              is_tick;
   } sched_resp_type;

   typedef struct {
      logic [1:0]        kind;
      logic signed [6:0] lo_val;
      logic [5:0]        hi_val;
   } cond_type;

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                start            = 1'b0;
   logic                busy;
   logic [1:0]          req_action       = ACT_NONE;
   logic [3:0]          req_task_index   = '0;
   logic [2:0]          req_field_select = '0;
   logic [1:0]          req_kind         = '0;
   logic signed [6:0]   req_value_a      = '0;
   logic [5:0]          req_value_b      = '0;
   logic [2:0]          req_list_slot    = '0;
   logic [5:0]          req_minute       = '0;
   logic [4:0]          req_hour         = '0;
   logic [4:0]          req_day_of_month = '0;
   logic [3:0]          req_month_number = '0;
   logic [2:0]          req_weekday      = '0;
   logic                rsp_valid;
   logic [MASK_W-1:0]   rsp_match_mask;
   logic                rsp_is_tick;
   logic                csr_wr_en        = 1'b0;
   logic [COUNT_W-1:0]  csr_wr_data      = '0;

   schedule_time_matcher uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_task_index   (req_task_index),
      .req_field_select (req_field_select),
      .req_kind         (req_kind),
      .req_value_a      (req_value_a),
      .req_value_b      (req_value_b),
      .req_list_slot    (req_list_slot),
      .req_minute       (req_minute),
      .req_hour         (req_hour),
      .req_day_of_month (req_day_of_month),
      .req_month_number (req_month_number),
      .req_weekday      (req_weekday),
      .rsp_valid        (rsp_valid),
      .rsp_match_mask   (rsp_match_mask),
      .rsp_is_tick      (rsp_is_tick),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always #6 clock = ~clock;

   // Mirror of the task table and of task_count as the block should hold them.
   cond_type           cond_tab [NUM_SLOTS];
   logic [ITEM_W-1:0]  list_tab [NUM_SLOTS][MAX_LIST_ITEMS_DEF];
   logic [COUNT_W-1:0] live_tasks = '0;

   // Requests waiting to be driven, and responses owed by the block.
   sched_req_type  sched_requests [$];
   sched_resp_type match_outcomes [$];
   sched_req_type  held_req;
   logic           accepted_now = 1'b0;

   // Which table entries the request stream has loaded so far.
   bit cond_loaded [NUM_SLOTS];
   bit item_loaded [NUM_SLOTS][MAX_LIST_ITEMS_DEF];
   int gen_tasks = 0;

   int idle_pct      = 25;
   int gap_left      = 0;
   int stall_cycles  = 0;
   int err_count     = 0;
   int ticks_checked = 0;
   int ticks_hit     = 0;
   int writes_acked  = 0;
   int counts_loaded = 0;

   // One field condition of the mirror table against one time value.
   function automatic bit field_hits(int slot, int t);
      cond_type c;
      int n;
      int i;
      bit hit;
      c = cond_tab[slot];
      hit = 1'b0;
      case (c.kind)
         KIND_SINGLE: begin
            hit = (c.lo_val == WILDCARD) || (int'(c.lo_val) == t);
         end
         KIND_LIST: begin
            n = (c.hi_val > MAX_LIST_ITEMS_DEF) ? MAX_LIST_ITEMS_DEF : int'(c.hi_val);
            for (i = 0; i < n; i++) begin
               if (int'(list_tab[slot][i]) == t) hit = 1'b1;
            end
         end
         KIND_RANGE: begin
            hit = (t >= int'(c.lo_val)) && (t <= int'(c.hi_val));
         end
         default: begin
            hit = 1'b0;
         end
      endcase
      return hit;
   endfunction

   // Applies one request to the mirror table and returns the response it owes.
   function automatic sched_resp_type match_request(sched_req_type r);
      sched_resp_type res;
      int slot;
      int limit;
      int row;
      int f;
      int now [NUM_FIELDS];
      bit hit;
      res.match_mask = '0;
      res.is_tick = 1'b0;
      slot = int'(r.task_index) * NUM_FIELDS + int'(r.field_select);
      case (r.action)
         ACT_WR_COND: begin
            if (r.field_select < NUM_FIELDS)
               cond_tab[slot] = '{kind: r.kind, lo_val: r.value_a, hi_val: r.value_b};
         end
         ACT_WR_ITEM: begin
            if (r.field_select < NUM_FIELDS && int'(r.list_slot) < MAX_LIST_ITEMS_DEF)
               list_tab[slot][r.list_slot] = r.value_a[ITEM_W-1:0];
         end
         ACT_TICK: begin
            now[FLD_MINUTE]  = int'(r.minute);
            now[FLD_HOUR]    = int'(r.hour);
            now[FLD_DAY]     = int'(r.day_of_month);
            now[FLD_MONTH]   = int'(r.month_number);
            now[FLD_WEEKDAY] = int'(r.weekday);
            limit = (live_tasks > MAX_TASKS_DEF) ? MAX_TASKS_DEF : int'(live_tasks);
            if (limit > MASK_W) limit = MASK_W;
            for (row = 0; row < limit; row++) begin
               hit = 1'b1;
               for (f = 0; f < NUM_FIELDS; f++) begin
                  if (!field_hits(row * NUM_FIELDS + f, now[f])) hit = 1'b0;
               end
               res.match_mask[row] = hit;
            end
            res.is_tick = 1'b1;
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   // A request with every field but the action random (action is ACT_NONE); callers set what matters.
   function automatic sched_req_type blank_request();
      sched_req_type rq;
      rq.action       = ACT_NONE;
      rq.task_index   = 4'($urandom);
      rq.field_select = 3'($urandom);
      rq.kind         = 2'($urandom);
      rq.value_a      = 7'($urandom);
      rq.value_b      = 6'($urandom);
      rq.list_slot    = 3'($urandom);
      rq.minute       = 6'($urandom);
      rq.hour         = 5'($urandom);
      rq.day_of_month = 5'($urandom);
      rq.month_number = 4'($urandom);
      rq.weekday      = 3'($urandom);
      return rq;
   endfunction

   function automatic int any_signed7();
      return int'($urandom_range(127)) - 64;
   endfunction

   // Small values dominate so that conditions and tick times meet often.
   function automatic int hot_value(int maxv);
      return ($urandom_range(99) < 65) ? int'($urandom_range(2)) : int'($urandom_range(maxv));
   endfunction

   function automatic void push_item(int row, int fsel, int slot, int v);
      sched_req_type rq;
      rq = blank_request();
      rq.action       = ACT_WR_ITEM;
      rq.task_index   = 4'(row);
      rq.field_select = 3'(fsel);
      rq.list_slot    = 3'(slot);
      rq.value_a      = 7'(v);
      sched_requests.push_back(rq);
      if (fsel < NUM_FIELDS) item_loaded[row * NUM_FIELDS + fsel][slot] = 1'b1;
   endfunction

   // A list condition first gets every item it will read loaded.
   function automatic void push_cond(int row, int fsel, logic [1:0] kind, int a, int b);
      sched_req_type rq;
      int s;
      int fill;
      if (kind == KIND_LIST && fsel < NUM_FIELDS) begin
         fill = (b > MAX_LIST_ITEMS_DEF) ? MAX_LIST_ITEMS_DEF : b;
         for (s = 0; s < fill; s++) begin
            if (!item_loaded[row * NUM_FIELDS + fsel][s]) push_item(row, fsel, s, hot_value(63));
         end
      end
      rq = blank_request();
      rq.action       = ACT_WR_COND;
      rq.task_index   = 4'(row);
      rq.field_select = 3'(fsel);
      rq.kind         = kind;
      rq.value_a      = 7'(a);
      rq.value_b      = 6'(b);
      sched_requests.push_back(rq);
      if (fsel < NUM_FIELDS) cond_loaded[row * NUM_FIELDS + fsel] = 1'b1;
   endfunction

   function automatic void push_random_cond(int row, int fsel);
      int pick;
      int a;
      int b;
      pick = $urandom_range(9);
      if (pick < 3) begin
         if ($urandom_range(9) < 6) a = -1;
         else a = ($urandom_range(3) == 0) ? any_signed7() : int'($urandom_range(2));
         push_cond(row, fsel, KIND_SINGLE, a, $urandom_range(63));
      end else if (pick < 6) begin
         a = ($urandom_range(3) == 0) ? any_signed7() : int'($urandom_range(2));
         b = ($urandom_range(3) == 0) ? int'($urandom_range(63)) : int'($urandom_range(59, 2));
         push_cond(row, fsel, KIND_RANGE, a, b);
      end else if (pick < 9) begin
         b = ($urandom_range(4) == 0) ? int'($urandom_range(63)) : int'($urandom_range(8, 1));
         push_cond(row, fsel, KIND_LIST, any_signed7(), b);
      end else begin
         push_cond(row, fsel, KIND_NEVER, any_signed7(), $urandom_range(63));
      end
   endfunction

   // A tick request; every condition it will read is loaded first.
   function automatic void push_tick(int mi, int h, int d, int mo, int w);
      sched_req_type rq;
      int rows;
      int row;
      int f;
      rows = (gen_tasks > MAX_TASKS_DEF) ? MAX_TASKS_DEF : gen_tasks;
      for (row = 0; row < rows; row++) begin
         for (f = 0; f < NUM_FIELDS; f++) begin
            if (!cond_loaded[row * NUM_FIELDS + f]) push_random_cond(row, f);
         end
      end
      rq = blank_request();
      rq.action       = ACT_TICK;
      rq.minute       = 6'(mi);
      rq.hour         = 5'(h);
      rq.day_of_month = 5'(d);
      rq.month_number = 4'(mo);
      rq.weekday      = 3'(w);
      sched_requests.push_back(rq);
   endfunction

   // Random mix of ticks, table writes and requests that the block ignores.
   function automatic void push_random_request();
      sched_req_type rq;
      int pick;
      pick = $urandom_range(99);
      if (pick < 35) begin
         push_tick(hot_value(63), hot_value(31), hot_value(31), hot_value(15), hot_value(7));
      end else if (pick < 65) begin
         push_random_cond($urandom_range(15), $urandom_range(4));
      end else if (pick < 85) begin
         push_item($urandom_range(15), $urandom_range(4), $urandom_range(7),
                   ($urandom_range(3) == 0) ? any_signed7() : hot_value(63));
      end else if (pick < 95) begin
         rq = blank_request();
         rq.action = ($urandom_range(1) == 0) ? ACT_WR_COND : ACT_WR_ITEM;
         rq.field_select = 3'($urandom_range(7, NUM_FIELDS));
         sched_requests.push_back(rq);
      end else begin
         sched_requests.push_back(blank_request());
      end
   endfunction

   // Waits until no request is pending or in flight and the block is idle.
   task automatic drain();
      while (sched_requests.size() != 0 || start || busy || match_outcomes.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic load_task_count(int v);
      drain();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= COUNT_W'(v);
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      live_tasks = COUNT_W'(v);
      gen_tasks = v;
      counts_loaded++;
   endtask

   // Driver: presents the next request at the falling edge, with random idle bursts.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || accepted_now) begin
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
            start <= 1'b0;
         end else if (sched_requests.size() == 0) begin
            start <= 1'b0;
         end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            gap_left = $urandom_range(11, 1) - 1;
            start <= 1'b0;
         end else begin
            held_req = sched_requests.pop_front();
            req_action       <= held_req.action;
            req_task_index   <= held_req.task_index;
            req_field_select <= held_req.field_select;
            req_kind         <= held_req.kind;
            req_value_a      <= held_req.value_a;
            req_value_b      <= held_req.value_b;
            req_list_slot    <= held_req.list_slot;
            req_minute       <= held_req.minute;
            req_hour         <= held_req.hour;
            req_day_of_month <= held_req.day_of_month;
            req_month_number <= held_req.month_number;
            req_weekday      <= held_req.weekday;
            start <= 1'b1;
         end
      end
   end

   // A request taken at this edge updates the mirror and owes one response.
   // The same block ends the run when nothing moves for too long.
   always @(posedge clock) begin : take_request
      bit took;
      took = !reset && start && !busy;
      accepted_now <= took;
      if (took) match_outcomes.push_back(match_request(held_req));
      if (reset || took || rsp_valid) begin
         stall_cycles = 0;
      end else begin
         stall_cycles = stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("No request or response moved for %0d cycles.", STALL_LIMIT);
            $display("schedule_time_matcher regression: fail");
            $finish;
         end
      end
   end

   // Monitor: each response is checked against the oldest one owed.
   always @(posedge clock) begin : check_response
      sched_resp_type want;
      if (!reset && rsp_valid) begin
         if (match_outcomes.size() == 0) begin
            $error("response with nothing owed: match_mask %h, is_tick %b",
                   rsp_match_mask, rsp_is_tick);
            err_count++;
         end else begin
            want = match_outcomes.pop_front();
            if (rsp_match_mask !== want.match_mask) begin
               $error("match_mask: expected %h, got %h", want.match_mask, rsp_match_mask);
               err_count++;
            end
            if (rsp_is_tick !== want.is_tick) begin
               $error("is_tick: expected %b, got %b", want.is_tick, rsp_is_tick);
               err_count++;
            end
            if (want.is_tick) begin
               ticks_checked++;
               if (want.match_mask != '0) ticks_hit++;
            end else begin
               writes_acked++;
            end
         end
      end
   end

   initial begin
      int ph;
      int n;
      int cnt;
      int first_counts [6];

      first_counts = '{16, 31, 0, 13, 1, 17};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // With no tasks in use a tick matches nothing; ignored requests still answer.
      push_tick(0, 0, 1, 1, 0);
      sched_requests.push_back(blank_request());
      push_cond(0, 7, KIND_RANGE, 0, 59);

      // Two hand-built tasks: wildcard, extreme values, saturated and negative
      // list items, and a condition of unknown kind.
      load_task_count(2);
      push_cond(0, FLD_MINUTE, KIND_SINGLE, -1, 0);
      push_cond(0, FLD_HOUR, KIND_SINGLE, 23, 63);
      push_cond(0, FLD_DAY, KIND_RANGE, 1, 31);
      push_cond(0, FLD_MONTH, KIND_LIST, 0, 2);
      push_item(0, FLD_MONTH, 0, 12);
      push_item(0, FLD_MONTH, 1, -1);
      push_cond(0, FLD_WEEKDAY, KIND_NEVER, 0, 0);
      push_cond(1, FLD_MINUTE, KIND_RANGE, -64, 63);
      push_cond(1, FLD_HOUR, KIND_SINGLE, 0, 0);
      push_cond(1, FLD_DAY, KIND_LIST, 63, 63);
      push_item(1, FLD_DAY, 7, 31);
      push_cond(1, FLD_MONTH, KIND_SINGLE, -1, 0);
      push_cond(1, FLD_WEEKDAY, KIND_SINGLE, 63, 0);
      push_tick(63, 0, 31, 15, 7);
      push_tick(0, 0, 0, 0, 0);
      push_cond(0, FLD_WEEKDAY, KIND_SINGLE, -1, 0);
      push_cond(1, FLD_WEEKDAY, KIND_SINGLE, -1, 0);
      push_tick(0, 23, 1, 12, 0);
      push_tick(63, 0, 31, 1, 6);
      push_tick(5, 23, 2, 1, 3);

      // Random phases, each under its own task count; the second, fifth, eighth and last run without gaps.
      for (ph = 0; ph < PHASES; ph++) begin
         if (ph < 6) cnt = first_counts[ph];
         else if ($urandom_range(3) == 0) cnt = $urandom_range(31);
         else cnt = $urandom_range(16, 1);
         load_task_count(cnt);
         if (ph == PHASES - 1 || ph % 3 == 1) idle_pct = 0;
         else idle_pct = $urandom_range(40, 10);
         for (n = 0; n < PHASE_ITEMS; n++) push_random_request();
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (match_outcomes.size() != 0) $error("%0d responses never arrived", match_outcomes.size());
      $display("Checked %0d ticks, %0d of them with matching tasks, and %0d write acknowledges.",
               ticks_checked, ticks_hit, writes_acked);
      $display("task_count was loaded %0d times, from zero up past the table size.",
               counts_loaded);
      if (err_count == 0 && match_outcomes.size() == 0) begin
         $display("schedule_time_matcher regression: pass");
      end else begin
         $display("schedule_time_matcher regression: fail");
      end
      $finish;
   end

endmodule

FILE: schedule_time_matcher.f
+incdir+hdl
hdl/stm_pkg.sv
hdl/stm_cond_mem.sv
hdl/stm_list_mem.sv
hdl/stm_match_eval.sv
hdl/schedule_time_matcher.sv
tb/tb_schedule_time_matcher.sv
